// File: src/prime_pair_span_test_unit_assert.svh
// ----------------------------------------------------------------------------
// prime pair span test unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PRIME_PAIR_SPAN_TEST_UNIT_ASSERT_SVH
`define PRIME_PAIR_SPAN_TEST_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PPST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PPST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/ppst_pkg.sv
// ----------------------------------------------------------------------------
// ppst_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ppst_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int SPAN_W      = 20;
   localparam int COUNT_W     = 32;
   localparam int FIELD_W     = 32;
   localparam int SUM_W       = ((VALUE_WIDTH > SPAN_W) ? VALUE_WIDTH : SPAN_W) + 1;
   localparam int DIV_W       = (VALUE_WIDTH + 1) / 2 + 2;
   localparam int SQ_W        = VALUE_WIDTH + 3;
   localparam int CNT_W       = $clog2(VALUE_WIDTH);

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_FIELD_W = 2 + 2 * FIELD_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 1'd1;

   localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(2);
   localparam logic [DIV_W-1:0]  FIRST_DIV  = DIV_W'(3);
   localparam logic [SQ_W-1:0]   FIRST_SQ   = SQ_W'(9);

   typedef struct packed {
      logic load_cand;
      logic load_partner;
      logic init_trial;
      logic step_trial;
      logic div_start;
      logic set_cprime;
      logic set_pair;
      logic emit;
   } ppst_cmd_type;

   typedef struct packed {
      logic n_is_two;
      logic n_is_bad;
      logic sq_over;
      logic div_done;
      logic rem_zero;
      logic pair_ok;
      logic out_free;
   } ppst_status_type;

endpackage

// File: src/ppst_rem_unit.sv
// ----------------------------------------------------------------------------
// ppst_rem_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module ppst_rem_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ppst_pkg::VALUE_WIDTH-1:0] dividend,
   input  logic [ppst_pkg::DIV_W-1:0]     divisor,
   output logic                           done,
   output logic [ppst_pkg::DIV_W-1:0]     remainder
);
   import ppst_pkg::*;

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [VALUE_WIDTH-1:0] shift_ff;
   logic [DIV_W-1:0]       dvs_ff;
   logic [DIV_W-1:0]       rem_ff;
   logic [DIV_W-1:0]       rem_in;
   logic [DIV_W:0]         part;
   logic [DIV_W:0]         dvs_ext;

   assign part    = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign dvs_ext = {1'b0, dvs_ff};

   // partial remainder stays below twice the divisor
   always_comb begin
      if (part >= dvs_ext) begin
         rem_in = DIV_W'(part - dvs_ext);
      end else begin
         rem_in = part[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(VALUE_WIDTH - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= dividend;
         dvs_ff   <= divisor;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         shift_ff <= shift_ff << 1;
         rem_ff   <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: src/ppst_datapath.sv
// ----------------------------------------------------------------------------
// ppst_datapath
// config registers, trial divisor state, flags, pair count, output word
// ----------------------------------------------------------------------------
module ppst_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ppst_pkg::ppst_cmd_type          cmd,
   output ppst_pkg::ppst_status_type       status,
   input  logic [ppst_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ppst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [ppst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ppst_pkg::*;

   logic [SPAN_W-1:0]      span_ff;
   logic [VALUE_WIDTH-1:0] upper_ff;
   logic [VALUE_WIDTH-1:0] n_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [DIV_W-1:0]       d_ff;
   logic [SQ_W-1:0]        dsq_ff;
   logic                   cprime_ff;
   logic                   pair_ff;
   logic [COUNT_W-1:0]     total_ff;
   logic [COUNT_W-1:0]     total_in;
   logic                   out_valid_ff;
   logic                   out_cprime_ff;
   logic                   out_pair_ff;
   logic [FIELD_W-1:0]     out_partner_ff;
   logic [COUNT_W-1:0]     out_total_ff;
   logic [VALUE_WIDTH-1:0] cand_v;
   logic                   div_done;
   logic [DIV_W-1:0]       rem;

   assign cand_v = req_tdata[VALUE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff  <= SPAN_RESET;
         upper_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPAN:  span_ff  <= csr_wdata[SPAN_W-1:0];
            CSR_UPPER: upper_ff <= csr_wdata[VALUE_WIDTH-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cand) begin
         n_ff      <= cand_v;
         sum_ff    <= SUM_W'(cand_v) + SUM_W'(span_ff);
         cprime_ff <= 1'b0;
         pair_ff   <= 1'b0;
      end else begin
         if (cmd.load_partner) begin
            n_ff <= sum_ff[VALUE_WIDTH-1:0];
         end
         if (cmd.set_cprime) begin
            cprime_ff <= 1'b1;
         end
         if (cmd.set_pair) begin
            pair_ff <= 1'b1;
         end
      end
      if (cmd.init_trial) begin
         d_ff   <= FIRST_DIV;
         dsq_ff <= FIRST_SQ;
      end else if (cmd.step_trial) begin
         d_ff   <= d_ff + DIV_W'(2);
         dsq_ff <= dsq_ff + SQ_W'({d_ff, 2'b00}) + SQ_W'(4);
      end
   end

   ppst_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .remainder (rem)
   );

   assign total_in = (pair_ff && (total_ff != '1)) ? total_ff + COUNT_W'(1) : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            total_ff     <= total_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // a reported pair always has sum within the bound, so it fits the value width
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_cprime_ff  <= cprime_ff;
         out_pair_ff    <= pair_ff;
         out_partner_ff <= pair_ff ? FIELD_W'(sum_ff[VALUE_WIDTH-1:0]) : '0;
         out_total_ff   <= total_in;
      end
   end

   assign status.n_is_two = (n_ff == VALUE_WIDTH'(2));
   assign status.n_is_bad = (!n_ff[0] && (n_ff != VALUE_WIDTH'(2)))
                            || (n_ff == VALUE_WIDTH'(1));
   assign status.sq_over  = (dsq_ff > SQ_W'(n_ff));
   assign status.div_done = div_done;
   assign status.rem_zero = (rem == '0);
   assign status.pair_ok  = !span_ff[0] && (sum_ff <= SUM_W'(upper_ff));
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_total_ff, out_partner_ff,
                        out_pair_ff, out_cprime_ff};

endmodule

// File: src/ppst_ctrl.sv
// ----------------------------------------------------------------------------
// ppst_ctrl
// sequencer for the candidate test, the partner test and result hand-off
// ----------------------------------------------------------------------------
module ppst_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  ppst_pkg::ppst_status_type status,
   output ppst_pkg::ppst_cmd_type    cmd
);
   import ppst_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TRIV = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_PASS = 3'd4;
   localparam logic [2:0] S_FAIL = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       phase_ff;
   logic       phase_in;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_cand = 1'b1;
               phase_in      = 1'b0;
               state_in      = S_TRIV;
            end
         end
         S_TRIV: begin
            if (status.n_is_two) begin
               state_in = S_PASS;
            end else if (status.n_is_bad) begin
               state_in = S_FAIL;
            end else begin
               cmd.init_trial = 1'b1;
               state_in       = S_SQ;
            end
         end
         S_SQ: begin
            if (status.sq_over) begin
               state_in = S_PASS;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  state_in = S_FAIL;
               end else begin
                  cmd.step_trial = 1'b1;
                  state_in       = S_SQ;
               end
            end
         end
         S_PASS: begin
            if (!phase_ff) begin
               cmd.set_cprime = 1'b1;
               if (status.pair_ok) begin
                  cmd.load_partner = 1'b1;
                  phase_in         = 1'b1;
                  state_in         = S_TRIV;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.set_pair = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_FAIL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: src/prime_pair_span_test_unit.sv
// ----------------------------------------------------------------------------
// prime_pair_span_test_unit
// tests a candidate for primality and whether candidate + span is its pair
// ----------------------------------------------------------------------------
// One word in, one word out. Each candidate is tested by trial division with
// odd divisors from 3 while the divisor squared stays within the value; every
// division runs through a bit-serial remainder unit at one dividend bit per
// cycle. A candidate that is 0, 1 or even other than 2 is settled without any
// division; otherwise up to sqrt(n) / 2 divisors are tried. When the candidate
// is prime, the span is even and the partner lies within upper_bound, the
// partner is tested the same way. Only one word is in work at a time; a
// finished result sits in an output register so the next word is taken while
// it waits. The user must write span and upper_bound through the csr port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module prime_pair_span_test_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request: [31:0] candidate
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ppst_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: [0] candidate_prime, [1] pair_found, [33:2] partner,
   // [65:34] pairs_so_far, [71:66] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ppst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // config: index 0 span, index 1 upper_bound
   input  logic                            csr_we,
   input  logic [ppst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ppst_pkg::*;

   // command and status between sequencer and datapath
   ppst_cmd_type    cmd;
   ppst_status_type status;

   // sequencer: trivial checks, divisor loop, partner pass, hand-off
   ppst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: config, divisor and square, remainder unit, count, output word
   ppst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// File: src/ppst_checker.sv
// ----------------------------------------------------------------------------
// ppst_checker
// port-level checks on the response channel
// ----------------------------------------------------------------------------
`include "prime_pair_span_test_unit_assert.svh"

module ppst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ppst_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ppst_pkg::*;

   logic stalled;
   logic pair_flag;
   logic prime_flag;
   logic valid_pair;
   logic valid_nopair;
   logic partner_clear;
   logic count_set;

   assign stalled       = rsp_tvalid && !rsp_tready;
   assign pair_flag     = rsp_tdata[1];
   assign prime_flag    = rsp_tdata[0];
   assign valid_pair    = rsp_tvalid && pair_flag;
   assign valid_nopair  = rsp_tvalid && !pair_flag;
   assign partner_clear = (rsp_tdata[33:2] == '0);
   assign count_set     = (rsp_tdata[65:34] != '0);

   `PPST_ASSERT_NEXT(a_valid_holds, clock, reset, stalled, rsp_tvalid, "rsp word dropped")
   `PPST_ASSERT_NEXT(a_word_holds, clock, reset, stalled, $stable(rsp_tdata), "rsp word changed")
   `PPST_ASSERT_NOW(a_pair_prime, clock, reset, valid_pair, prime_flag, "pair without prime")
   `PPST_ASSERT_NOW(a_partner_zero, clock, reset, valid_nopair, partner_clear, "stray partner")
   `PPST_ASSERT_NOW(a_count_set, clock, reset, valid_pair, count_set, "pair not counted")

endmodule

bind prime_pair_span_test_unit ppst_checker u_checker (.*);

// File: tb/prime_pair_span_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_pair_span_test_unit_tb
// self-checking bench for the prime pair span tester
// ----------------------------------------------------------------------------
// A table of directed words and register writes runs first: zero, one, two,
// even and odd values, the widest words, odd and zero span, a zero and a tight
// upper bound, and a partner that runs past the top of the word. Random words
// follow in four phases with fresh register values each time and different
// amounts of source idling and sink back-pressure. Every response word is
// checked field by field against a trial-division predictor or a known table answer.
// ----------------------------------------------------------------------------
module prime_pair_span_test_unit_tb;
   import ppst_pkg::*;

   // one predicted response word
   typedef struct packed {
      logic        cand_prime;
      logic        pair_found;
      logic [31:0] partner;
      logic [31:0] pairs_so_far;
   } span_verdict_type;

   // directed table: plain word, word with a known answer, or register write
   typedef enum logic [1:0] {
      ROW_WORD,
      ROW_KNOWN,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [31:0]            value;
      span_verdict_type       known;
   } plan_row_type;

   // idling phases of the random part
   typedef enum int {
      IDLE_NONE,
      IDLE_SOURCE,
      IDLE_SINK,
      IDLE_BOTH
   } idle_mode_type;

   localparam int               PLAN_ROWS     = 29;
   localparam int               PHASE_WORDS   = 20;
   localparam int               SETTLE_CYCLES = 16;
   localparam span_verdict_type NO_VERDICT    = '0;

   // widest prime of the word: with the widest even span its partner overflows
   localparam logic [31:0]   TOP_PRIME     = 32'd4294967291;
   localparam logic [31:0]   SPAN_TOP_EVEN = 32'd1048574;
   localparam logic [31:0]   SPAN_TOP      = 32'd1048575;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of the registers and the pair counter
   logic [SPAN_W-1:0]     model_span;
   logic [31:0]           model_bound;
   logic [31:0]           model_pairs;

   span_verdict_type      pending_verdicts[$];
   int                    error_count;
   idle_mode_type         idle_mode;

   // directed table, walked in order
   plan_row_type plan [PLAN_ROWS] = '{
      // answers readable at a glance: small values and the widest words
      '{ROW_KNOWN, CSR_SPAN,  32'd0,          '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{ROW_KNOWN, CSR_SPAN,  32'd1,          '{1'b0, 1'b0, 32'd0, 32'd0}},
      '{ROW_KNOWN, CSR_SPAN,  32'd2,          '{1'b1, 1'b0, 32'd0, 32'd0}},
      '{ROW_KNOWN, CSR_SPAN,  32'd3,          '{1'b1, 1'b1, 32'd5, 32'd1}},
      '{ROW_KNOWN, CSR_SPAN,  32'd4,          '{1'b0, 1'b0, 32'd0, 32'd1}},
      '{ROW_KNOWN, CSR_SPAN,  32'd5,          '{1'b1, 1'b1, 32'd7, 32'd2}},
      '{ROW_WORD,  CSR_SPAN,  32'd25,         NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd29,         NO_VERDICT},
      '{ROW_KNOWN, CSR_SPAN,  32'hFFFF_FFFF,  '{1'b0, 1'b0, 32'd0, 32'd3}},
      '{ROW_KNOWN, CSR_SPAN,  32'hFFFF_FFFE,  '{1'b0, 1'b0, 32'd0, 32'd3}},
      '{ROW_KNOWN, CSR_SPAN,  32'h8000_0000,  '{1'b0, 1'b0, 32'd0, 32'd3}},
      // odd span never pairs
      '{ROW_CSR,   CSR_SPAN,  32'd3,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd3,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd11,         NO_VERDICT},
      // zero span: a prime pairs with itself
      '{ROW_CSR,   CSR_SPAN,  32'd0,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd2,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd7,          NO_VERDICT},
      // zero bound blocks every pair
      '{ROW_CSR,   CSR_UPPER, 32'd0,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd3,          NO_VERDICT},
      // partner right on the bound, then just past it
      '{ROW_CSR,   CSR_SPAN,  32'd4,          NO_VERDICT},
      '{ROW_CSR,   CSR_UPPER, 32'd7,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd3,          NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd7,          NO_VERDICT},
      // partner past the top of the word
      '{ROW_CSR,   CSR_SPAN,  SPAN_TOP_EVEN,  NO_VERDICT},
      '{ROW_CSR,   CSR_UPPER, 32'hFFFF_FFFF,  NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  TOP_PRIME,      NO_VERDICT},
      // widest span is odd
      '{ROW_CSR,   CSR_SPAN,  SPAN_TOP,       NO_VERDICT},
      '{ROW_WORD,  CSR_SPAN,  32'd13,         NO_VERDICT},
      '{ROW_CSR,   CSR_SPAN,  32'd2,          NO_VERDICT}
   };

   prime_pair_span_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] candidate
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] prime, [1] pair, [33:2] partner, [65:34] count
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // trial division by odd divisors
   function automatic bit is_prime_number(input logic [63:0] n);
      logic [63:0] d;
      if (n == 64'd2)
         return 1'b1;
      if (n < 64'd2 || n[0] == 1'b0)
         return 1'b0;
      for (d = 64'd3; d * d <= n; d += 64'd2) begin
         if (n % d == 64'd0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // response for one candidate; advances the pair counter
   function automatic span_verdict_type judge_candidate(input logic [31:0] cand);
      logic [63:0]      total;
      span_verdict_type v;
      // bound test runs on the true sum, before any saturation
      total = {32'd0, cand} + {{(64 - SPAN_W){1'b0}}, model_span};
      v = '0;
      v.cand_prime = is_prime_number({32'd0, cand});
      if (v.cand_prime && !model_span[0] && total <= {32'd0, model_bound})
         v.pair_found = is_prime_number(total);
      if (v.pair_found) begin
         // a pair is within the bound, so the partner never saturates here
         v.partner = total[31:0];
         if (model_pairs != 32'hFFFF_FFFF)
            model_pairs = model_pairs + 32'd1;
      end
      v.pairs_so_far = model_pairs;
      return v;
   endfunction

   function automatic int source_idle_pct();
      case (idle_mode)
         IDLE_SOURCE: return 65;
         IDLE_BOTH:   return 26;
         default:     return 0;
      endcase
   endfunction

   function automatic int sink_stall_pct();
      case (idle_mode)
         IDLE_SINK: return 65;
         IDLE_BOTH: return 26;
         default:   return 0;
      endcase
   endfunction

   // mostly small values so that primes and pairs come often and cheaply;
   // wide values are even or multiples of three so that they fail fast
   function automatic logic [31:0] random_candidate();
      logic [31:0] v;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         v = $urandom_range(0, 4095);
         if (pick <= 4)
            v[0] = 1'b1;
      end else if (pick == 6) begin
         v = $urandom_range(0, 4095);
         v[0] = 1'b0;
      end else if (pick == 7) begin
         v = $urandom;
         v[0] = 1'b0;
      end else begin
         v = $urandom;
         v = v - v % 32'd3;
      end
      return v;
   endfunction

   // sink back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct());
   end

   // one word into the block; called and left at a falling edge
   task automatic send_word(input logic [31:0] cand, input bit known,
                            input span_verdict_type known_v);
      int               gap;
      span_verdict_type v;
      gap = 0;
      while ($urandom_range(0, 99) < source_idle_pct())
         gap++;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = cand;
      do
         @(posedge clock);
      while (!req_tready);
      // the predictor always runs so the pair counter stays in step
      v = judge_candidate(cand);
      pending_verdicts.push_back(known ? known_v : v);
      @(negedge clock);
   endtask

   // wait for every outstanding response, then let the block stay quiet a while
   task automatic settle_block();
      req_tvalid = 1'b0;
      while (pending_verdicts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      if (idx == CSR_SPAN)
         model_span = value[SPAN_W-1:0];
      else
         model_bound = value;
   endtask

   // response checker
   always @(posedge clock) begin
      span_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response word with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== want.cand_prime) begin
               $error("candidate_prime: expected %0d, got %0d",
                      want.cand_prime, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== want.pair_found) begin
               $error("pair_found: expected %0d, got %0d",
                      want.pair_found, rsp_tdata[1]);
               error_count++;
            end
            if (rsp_tdata[33:2] !== want.partner) begin
               $error("partner: expected %0d, got %0d", want.partner, rsp_tdata[33:2]);
               error_count++;
            end
            if (rsp_tdata[65:34] !== want.pairs_so_far) begin
               $error("pairs_so_far: expected %0d, got %0d",
                      want.pairs_so_far, rsp_tdata[65:34]);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] span_pick;
      logic [31:0] bound_pick;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_SPAN;
      csr_wdata   = '0;
      error_count = 0;
      idle_mode   = IDLE_NONE;
      model_span  = SPAN_RESET;
      model_bound = 32'hFFFF_FFFF;
      model_pairs = 32'd0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, no idling
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].kind == ROW_CSR) begin
            settle_block();
            write_csr(plan[r].index, plan[r].value);
         end else begin
            send_word(plan[r].value, plan[r].kind == ROW_KNOWN, plan[r].known);
         end
      end

      // random phases, one per idling mode, fresh registers each time
      for (int p = 0; p < 4; p++) begin
         settle_block();
         idle_mode = idle_mode_type'(p);
         case ($urandom_range(0, 3))
            0:       span_pick = 32'd2;
            1:       span_pick = 32'($urandom_range(0, 32)) * 32'd2;
            2:       span_pick = $urandom_range(0, 32'hF_FFFF);
            default: span_pick = 32'd6;
         endcase
         case ($urandom_range(0, 3))
            0, 1:    bound_pick = 32'hFFFF_FFFF;
            2:       bound_pick = $urandom_range(0, 8191);
            default: bound_pick = $urandom;
         endcase
         write_csr(CSR_SPAN, span_pick);
         write_csr(CSR_UPPER, bound_pick);
         for (int i = 0; i < PHASE_WORDS; i++)
            send_word(random_candidate(), 1'b0, NO_VERDICT);
      end

      // drain and finish
      idle_mode = IDLE_NONE;
      settle_block();
      if (pending_verdicts.size() != 0) begin
         $error("%0d responses never arrived", pending_verdicts.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: prime_pair_span_test_unit.f
+incdir+src
src/ppst_pkg.sv
src/ppst_rem_unit.sv
src/ppst_datapath.sv
src/ppst_ctrl.sv
src/prime_pair_span_test_unit.sv
src/ppst_checker.sv
tb/prime_pair_span_test_unit_tb.sv
